@@ rtl/cfab_pkg.sv @@
`timescale 1ns / 1ps
// cfab_pkg: shared types and constants for the circle fill and alpha blend block
// holds operation codes, register indexes and the draw issue struct
// no dependencies
package cfab_pkg;

	// field widths
	localparam int CFG_W   = 9;   // canvas size register width
	localparam int COORD_W = 12;  // signed pixel coordinate width
	localparam int RAD_W   = 12;  // radius width
	localparam int DIFF_W  = 13;  // signed pixel minus center difference
	localparam int DIST_W  = 24;  // squared distance and squared radius
	localparam int CH_W    = 8;   // one color channel
	localparam int PIX_W   = 32;  // one stored pixel, red in the low byte

	// operation codes carried on s_tuser
	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_DRAW  = 2'd2
	} func_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	// one pixel visit handed from the sweep counters to the blend pipeline
	typedef struct packed {
		logic                     vld;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} draw_issue_t;

endpackage

@@ rtl/cfab_frame_mem.sv @@
`timescale 1ns / 1ps
// cfab_frame_mem: frame store, one write port and one registered read port
// depends on cfab_pkg for the pixel width
module cfab_frame_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [cfab_pkg::PIX_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [cfab_pkg::PIX_W-1:0] rdata
);

	logic [cfab_pkg::PIX_W-1:0] mem [0:DEPTH-1];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/cfab_draw_pipe.sv @@
`timescale 1ns / 1ps
// cfab_draw_pipe: inside test and alpha blend for one pixel per cycle
// depends on cfab_pkg; takes frame store read data in the cycle after issue
module cfab_draw_pipe #(
	parameter int AW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfab_pkg::draw_issue_t       issue,
	input  logic [AW-1:0]               issue_addr,
	input  logic [cfab_pkg::PIX_W-1:0]  rd_data,
	input  logic [cfab_pkg::PIX_W-1:0]  src_color,
	input  logic [cfab_pkg::DIST_W-1:0] r2,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [cfab_pkg::PIX_W-1:0]  wr_data,
	output logic                        busy
);

	localparam int NCH   = cfab_pkg::PIX_W / cfab_pkg::CH_W;
	localparam int MIX_W = 2 * cfab_pkg::CH_W;
	localparam int SQ_W  = 2 * cfab_pkg::DIFF_W;

	// floor(v / 255) for v up to 255*255
	function automatic logic [cfab_pkg::CH_W-1:0] div255(input logic [MIX_W-1:0] v);
		logic [MIX_W:0] t;
		t = {1'b0, v} + {{(cfab_pkg::CH_W+1){1'b0}}, v[MIX_W-1:cfab_pkg::CH_W]}
			+ {{MIX_W{1'b0}}, 1'b1};
		return t[MIX_W-1:cfab_pkg::CH_W];
	endfunction

	logic                               vld_s1;
	logic [AW-1:0]                      addr_s1;
	logic signed [cfab_pkg::DIFF_W-1:0] dx_s1;
	logic signed [cfab_pkg::DIFF_W-1:0] dy_s1;

	logic                               vld_s2;
	logic [AW-1:0]                      addr_s2;
	logic [cfab_pkg::DIST_W-1:0]        dist_s2;
	logic [MIX_W-1:0]                   mix_s2 [NCH];

	logic signed [SQ_W-1:0]             sqx;
	logic signed [SQ_W-1:0]             sqy;
	logic [MIX_W-1:0]                   mix_c [NCH];
	logic [cfab_pkg::CH_W-1:0]          alpha;

	assign alpha = src_color[cfab_pkg::PIX_W-1 -: cfab_pkg::CH_W];

	// squared distance of the pixel from the center
	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;

	// weighted channel sums, dst*(255-a) + src*a
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			mix_c[c] = {{cfab_pkg::CH_W{1'b0}}, rd_data[c*cfab_pkg::CH_W +: cfab_pkg::CH_W]}
					* {{cfab_pkg::CH_W{1'b0}}, ~alpha}
				+ {{cfab_pkg::CH_W{1'b0}}, src_color[c*cfab_pkg::CH_W +: cfab_pkg::CH_W]}
					* {{cfab_pkg::CH_W{1'b0}}, alpha};
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue.vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		addr_s1 <= issue_addr;
		dx_s1   <= issue.dx;
		dy_s1   <= issue.dy;
		addr_s2 <= addr_s1;
		dist_s2 <= sqx[cfab_pkg::DIST_W-1:0] + sqy[cfab_pkg::DIST_W-1:0];
		for (int c = 0; c < NCH; c++) begin
			mix_s2[c] <= mix_c[c];
		end
	end

	// write back blended pixel when strictly inside the circle
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			wr_data[c*cfab_pkg::CH_W +: cfab_pkg::CH_W] = div255(mix_s2[c]);
		end
	end

	assign wr_en   = vld_s2 && (dist_s2 < r2);
	assign wr_addr = addr_s2;
	assign busy    = vld_s1 || vld_s2;

endmodule

@@ rtl/circle_fill_alpha_blend.sv @@
`timescale 1ns / 1ps
// circle_fill_alpha_blend: top level with item control, canvas sweep and result register
// depends on cfab_pkg, cfab_frame_mem and cfab_draw_pipe
//
// An RGBA frame store of MAX_WIDTH by MAX_HEIGHT pixels that takes three kinds of
// item: write pixel, read pixel and draw circle. After reset the block sweeps the
// frame store to zero, one pixel a cycle, and s_tready stays low until that pass ends;
// configuration transfers are taken during that pass. Items are handled one at a
// time. Write and read pass through the state register and then the result register
// from input transfer to the earliest result transfer. A draw visits every pixel of
// the canvas with one read-modify-write of the single frame store per cycle, set by
// the one read port and one write port of that store, and its result waits for the
// blend pipeline to drain at the end. The result register lets the next item be taken
// while a result waits on m_tready.
module circle_fill_alpha_blend #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input items
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [71:0]                s_tdata,   // pos_x, pos_y, radius, red, green, blue, alpha
	input  logic [1:0]                 s_tuser,   // func
	// results
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // read_red, read_green, read_blue, read_alpha
	output logic                       m_tuser,   // status
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [cfab_pkg::CFG_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = cfab_pkg::CFG_W;
	localparam int XW    = cfab_pkg::COORD_W - 1;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_DRAW  = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	state_t                                 state_q;
	logic [AW-1:0]                          clr_addr_q;
	logic [CW-1:0]                          cfg_w_q;
	logic [CW-1:0]                          cfg_h_q;
	logic [CW-1:0]                          w_q;
	logic [CW-1:0]                          h_q;
	logic [CW-1:0]                          x_q;
	logic [CW-1:0]                          y_q;
	logic signed [cfab_pkg::COORD_W-1:0]    px_q;
	logic signed [cfab_pkg::COORD_W-1:0]    py_q;
	logic [cfab_pkg::DIST_W-1:0]            r2_q;
	logic [cfab_pkg::PIX_W-1:0]             color_q;
	cfab_pkg::func_t                        func_q;
	logic                                   status_q;
	logic                                   out_valid_q;
	logic [cfab_pkg::PIX_W-1:0]             out_data_q;
	logic                                   out_status_q;

	logic [cfab_pkg::COORD_W-1:0]           in_pos_x;
	logic [cfab_pkg::COORD_W-1:0]           in_pos_y;
	logic [cfab_pkg::RAD_W-1:0]             in_radius;
	logic [cfab_pkg::PIX_W-1:0]             in_color;
	cfab_pkg::func_t                        in_func;
	logic [CW-1:0]                          eff_w;
	logic [CW-1:0]                          eff_h;
	logic                                   in_bounds;
	logic [AW-1:0]                          in_addr;
	logic                                   accept;
	logic                                   out_load;

	cfab_pkg::draw_issue_t                  issue;
	logic [AW-1:0]                          draw_addr;
	logic                                   last_x;
	logic                                   last_y;

	logic                                   mem_we;
	logic [AW-1:0]                          mem_waddr;
	logic [cfab_pkg::PIX_W-1:0]             mem_wdata;
	logic                                   mem_re;
	logic [AW-1:0]                          mem_raddr;
	logic [cfab_pkg::PIX_W-1:0]             mem_rdata;

	logic                                   pipe_we;
	logic [AW-1:0]                          pipe_waddr;
	logic [cfab_pkg::PIX_W-1:0]             pipe_wdata;
	logic                                   pipe_busy;

	// input field unpacking
	assign in_pos_x  = s_tdata[11:0];
	assign in_pos_y  = s_tdata[23:12];
	assign in_radius = s_tdata[35:24];
	assign in_color  = s_tdata[67:36];
	assign in_func   = cfab_pkg::func_t'(s_tuser);

	// canvas size limited to the frame store
	assign eff_w = ({3'b000, cfg_w_q} > 12'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : cfg_w_q;
	assign eff_h = ({3'b000, cfg_h_q} > 12'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : cfg_h_q;

	// single pixel bounds check and address
	assign in_bounds = !in_pos_x[XW] && !in_pos_y[XW]
		&& (in_pos_x[XW-1:0] < {2'b00, eff_w}) && (in_pos_y[XW-1:0] < {2'b00, eff_h});
	assign in_addr   = AW'(in_pos_y[XW-1:0]) * AW'(MAX_WIDTH) + AW'(in_pos_x[XW-1:0]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// sweep position
	assign last_x    = (x_q == w_q - CW'(1));
	assign last_y    = (y_q == h_q - CW'(1));
	assign draw_addr = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);
	assign issue.vld = (state_q == ST_DRAW);
	assign issue.dx  = $signed({4'b0000, x_q}) - $signed({px_q[XW], px_q});
	assign issue.dy  = $signed({4'b0000, y_q}) - $signed({py_q[XW], py_q});

	// frame store port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pipe_waddr;
		mem_wdata = pipe_wdata;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (pipe_we) begin
			mem_we = 1'b1;
		end else if (accept && in_func == cfab_pkg::FUNC_WRITE && in_bounds) begin
			mem_we    = 1'b1;
			mem_waddr = in_addr;
			mem_wdata = in_color;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = draw_addr;
		if (state_q == ST_DRAW) begin
			mem_re = 1'b1;
		end else if (accept && in_func == cfab_pkg::FUNC_READ && in_bounds) begin
			mem_re    = 1'b1;
			mem_raddr = in_addr;
		end
	end

	cfab_frame_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cfab_draw_pipe #(
		.AW (AW)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.issue_addr (draw_addr),
		.rd_data    (mem_rdata),
		.src_color  (color_q),
		.r2         (r2_q),
		.wr_en      (pipe_we),
		.wr_addr    (pipe_waddr),
		.wr_data    (pipe_wdata),
		.busy       (pipe_busy)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CW'(256);
			cfg_h_q <= CW'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfab_pkg::cfg_idx_t'(cfg_index))
				cfab_pkg::CFG_WIDTH:  cfg_w_q <= cfg_data;
				cfab_pkg::CFG_HEIGHT: cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item control and canvas sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			x_q        <= '0;
			y_q        <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					x_q <= '0;
					y_q <= '0;
					if (accept) begin
						if (in_func == cfab_pkg::FUNC_DRAW && eff_w != '0 && eff_h != '0) begin
							state_q <= ST_DRAW;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_DRAW: begin
					if (last_x) begin
						x_q <= '0;
						y_q <= y_q + CW'(1);
						if (last_y) begin
							state_q <= ST_RESP;
						end
					end else begin
						x_q <= x_q + CW'(1);
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item fields captured at the input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= in_func;
			status_q <= (in_func == cfab_pkg::FUNC_WRITE || in_func == cfab_pkg::FUNC_READ)
				&& !in_bounds;
			px_q     <= $signed(in_pos_x);
			py_q     <= $signed(in_pos_y);
			r2_q     <= {12'd0, in_radius} * {12'd0, in_radius};
			color_q  <= in_color;
			w_q      <= eff_w;
			h_q      <= eff_h;
		end
	end

	// result register
	assign out_load = (state_q == ST_RESP) && !pipe_busy && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_data_q   <= (func_q == cfab_pkg::FUNC_READ && !status_q) ? mem_rdata : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

`ifndef SYNTHESIS
	// blended writes only come while a draw is sweeping or draining
	assert property (@(posedge clk) disable iff (!arst_n)
		pipe_we |-> (state_q == ST_DRAW || state_q == ST_RESP))
		else $error("draw write outside a draw");

	// a result is never posted while blended writes are still in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !pipe_busy)
		else $error("result posted before draw drained");

	// the sweep stays inside the latched canvas
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> (x_q < w_q && y_q < h_q))
		else $error("sweep outside canvas");

	// an accepted item always leaves idle on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DRAW || state_q == ST_RESP))
		else $error("accepted item not started");
`endif

endmodule
